// ===== hw/rtl/mbrtu_pkg.sv =====
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Shared types, constants and the byte-wise CRC-16 for the RTU request parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mbrtu_pkg;

  localparam int PAYLOAD_BYTES = 256;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'd1;

  localparam logic [7:0] FC_READ_COILS = 8'h01;
  localparam logic [7:0] FC_READ_INPUTS_DISC = 8'h02;
  localparam logic [7:0] FC_READ_HOLDING = 8'h03;
  localparam logic [7:0] FC_READ_INPUT_REGS = 8'h04;
  localparam logic [7:0] FC_WRITE_COIL = 8'h05;
  localparam logic [7:0] FC_WRITE_REG = 8'h06;
  localparam logic [7:0] FC_WRITE_COILS = 8'h0F;
  localparam logic [7:0] FC_WRITE_REGS = 8'h10;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_CRC_ERROR = 2'd1,
    STATUS_OTHER     = 2'd2
  } frame_status_t;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'd0,
    ST_FUNC    = 4'd1,
    ST_ADDR_HI = 4'd2,
    ST_ADDR_LO = 4'd3,
    ST_NUM_HI  = 4'd4,
    ST_NUM_LO  = 4'd5,
    ST_WORD_HI = 4'd6,
    ST_WORD_LO = 4'd7,
    ST_SIZE    = 4'd8,
    ST_PAYLOAD = 4'd9,
    ST_CRC_LO  = 4'd10,
    ST_CRC_HI  = 4'd11
  } parse_state_t;

  typedef struct packed {
    logic          data_write;
    logic [7:0]    data_index;
    logic [7:0]    data_byte;
    logic          frame_end;
    frame_status_t frame_status;
    logic [7:0]    func_code;
    logic [15:0]   reg_address;
    logic [15:0]   quantity;
    logic [7:0]    byte_count;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic is_read(input logic [7:0] f);
    return f inside {FC_READ_COILS, FC_READ_INPUTS_DISC, FC_READ_HOLDING,
                     FC_READ_INPUT_REGS};
  endfunction

  function automatic logic is_single_write(input logic [7:0] f);
    return f inside {FC_WRITE_COIL, FC_WRITE_REG};
  endfunction

  function automatic logic is_multi_write(input logic [7:0] f);
    return f inside {FC_WRITE_COILS, FC_WRITE_REGS};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mbrtu_parser.sv =====
// ----------------------------------------------------------------------------
// mbrtu_parser
// Frame state machine, field registers and running CRC; forms one result per
// accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrtu_parser
  import mbrtu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        accept,
  input  wire logic [7:0]  rx_byte,
  output result_t          res
);

  parse_state_t state, state_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  device_address;
  logic [7:0]  frame_addr, frame_addr_next;
  logic [7:0]  frame_func, frame_func_next;
  logic [15:0] start_addr, start_addr_next;
  logic [15:0] count_total, count_total_next;
  logic [7:0]  payload_size, payload_size_next;
  logic [7:0]  payload_left, payload_left_next;
  logic [15:0] crc_upd;
  logic [15:0] crc_start;
  logic [7:0]  pay_idx;
  logic        supported;

  assign crc_upd   = crc_byte(crc, rx_byte);
  assign crc_start = crc_byte(CRC_INIT, rx_byte);
  assign pay_idx   = payload_size - payload_left;
  assign supported = is_read(rx_byte) || is_single_write(rx_byte) ||
                     is_multi_write(rx_byte);

  always_comb begin
    case (state)
      ST_FUNC:    state_next = supported ? ST_ADDR_HI : ST_IDLE;
      ST_ADDR_HI: state_next = ST_ADDR_LO;
      ST_ADDR_LO: state_next = is_single_write(frame_func) ? ST_WORD_HI : ST_NUM_HI;
      ST_NUM_HI:  state_next = ST_NUM_LO;
      ST_NUM_LO:  state_next = is_multi_write(frame_func) ? ST_SIZE : ST_CRC_LO;
      ST_WORD_HI: state_next = ST_WORD_LO;
      ST_WORD_LO: state_next = ST_CRC_LO;
      ST_SIZE:    state_next = (rx_byte == 8'd0) ? ST_CRC_LO : ST_PAYLOAD;
      ST_PAYLOAD: state_next = (payload_left == 8'd1) ? ST_CRC_LO : ST_PAYLOAD;
      ST_CRC_LO:  state_next = ST_CRC_HI;
      ST_CRC_HI:  state_next = ST_IDLE;
      default:    state_next = ST_FUNC;
    endcase
  end

  always_comb begin
    res               = '0;
    crc_next          = crc_upd;
    frame_addr_next   = frame_addr;
    frame_func_next   = frame_func;
    start_addr_next   = start_addr;
    count_total_next  = count_total;
    payload_size_next = payload_size;
    payload_left_next = payload_left;
    case (state)
      ST_FUNC: begin
        frame_func_next = rx_byte;
        if (is_single_write(rx_byte)) begin
          count_total_next = 16'd1;
        end else if (supported) begin
          count_total_next = 16'd0;
        end else begin
          crc_next = CRC_INIT;
        end
      end
      ST_ADDR_HI: start_addr_next = {rx_byte, 8'h00};
      ST_ADDR_LO: start_addr_next = {start_addr[15:8], rx_byte};
      ST_NUM_HI:  count_total_next = {rx_byte, 8'h00};
      ST_NUM_LO:  count_total_next = {count_total[15:8], rx_byte};
      ST_WORD_HI: begin
        res.data_write = 1'b1;
        res.data_index = 8'd1;
        res.data_byte  = rx_byte;
      end
      ST_WORD_LO: begin
        res.data_write = 1'b1;
        res.data_index = 8'd0;
        res.data_byte  = rx_byte;
      end
      ST_SIZE: begin
        payload_size_next = rx_byte;
        payload_left_next = rx_byte;
      end
      ST_PAYLOAD: begin
        if ({1'b0, pay_idx} < 9'(PAYLOAD_BYTES)) begin
          res.data_write = 1'b1;
          res.data_index = pay_idx;
          res.data_byte  = rx_byte;
        end
        payload_left_next = payload_left - 8'd1;
      end
      ST_CRC_LO: ;
      ST_CRC_HI: begin
        crc_next        = CRC_INIT;
        res.frame_end   = 1'b1;
        if (crc_upd != 16'd0) begin
          res.frame_status = STATUS_CRC_ERROR;
        end else if (frame_addr == device_address) begin
          res.frame_status = STATUS_OK;
        end else begin
          res.frame_status = STATUS_OTHER;
        end
        res.func_code   = frame_func;
        res.reg_address = start_addr;
        res.quantity    = count_total;
        res.byte_count  = is_multi_write(frame_func) ? payload_size : 8'd0;
      end
      default: begin
        crc_next          = crc_start;
        frame_addr_next   = rx_byte;
        frame_func_next   = 8'd0;
        start_addr_next   = 16'd0;
        count_total_next  = 16'd0;
        payload_size_next = 8'd0;
        payload_left_next = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEVICE_ADDRESS_RESET;
    end else if (cfg_wen) begin
      device_address <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      crc          <= CRC_INIT;
      frame_addr   <= 8'd0;
      frame_func   <= 8'd0;
      start_addr   <= 16'd0;
      count_total  <= 16'd0;
      payload_size <= 8'd0;
      payload_left <= 8'd0;
    end else if (accept) begin
      state        <= state_next;
      crc          <= crc_next;
      frame_addr   <= frame_addr_next;
      frame_func   <= frame_func_next;
      start_addr   <= start_addr_next;
      count_total  <= count_total_next;
      payload_size <= payload_size_next;
      payload_left <= payload_left_next;
    end
  end

  a_end_returns_idle: assert property (@(posedge clk) disable iff (rst)
    accept && res.frame_end |=> state == ST_IDLE && crc == CRC_INIT)
    else $error("parser did not return to idle after a frame end");

  a_write_not_end: assert property (@(posedge clk) disable iff (rst)
    accept |-> !(res.data_write && res.frame_end))
    else $error("payload write and frame end in one result");

  a_bad_func_drops: assert property (@(posedge clk) disable iff (rst)
    accept && state == ST_FUNC && !supported |=> state == ST_IDLE && crc == CRC_INIT)
    else $error("unsupported function code did not reset the parser");

  a_idle_starts_frame: assert property (@(posedge clk) disable iff (rst)
    accept && state == ST_IDLE |=> state == ST_FUNC && frame_addr == $past(rx_byte))
    else $error("first byte of a frame not captured as its address");

endmodule

`default_nettype wire

// ===== hw/rtl/mbrtu_out_reg.sv =====
// ----------------------------------------------------------------------------
// mbrtu_out_reg
// Result register between the parser and the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrtu_out_reg
  import mbrtu_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t res_in,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      res_out
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_ready) begin
      res_out <= res_in;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/modbus_rtu_request_parser_core.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_request_parser_core
// Slave-side Modbus RTU request parser with CRC-16 check, one byte per beat.
// ----------------------------------------------------------------------------
// Each received byte is one input transaction and yields exactly one output
// transaction in the following cycle; a new byte is taken every cycle while the
// output side keeps up, the whole state step and byte-wise CRC being done
// combinationally ahead of the result register. Payload bytes appear with tuser set
// and their buffer index; the last CRC byte of a frame appears with tlast set
// and the frame status (0 accepted, 1 CRC error, 2 other address) and fields.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_request_parser_core
  import mbrtu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [7:0]  cfg_wdata,    // device_address
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,      // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,      // [7:0] data_index, [15:8] data_byte,
                                         // [17:16] frame_status, [25:18] func_code,
                                         // [41:26] reg_address, [57:42] quantity,
                                         // [65:58] byte_count, [71:66] zero
  output logic             m_tuser,      // [0] data_write
  output logic             m_tlast       // frame_end
);

  logic    accept;
  result_t res;
  result_t res_q;

  assign accept = s_tvalid && s_tready;

  mbrtu_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .rx_byte   (s_tdata),
    .res       (res)
  );

  mbrtu_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (s_tvalid),
    .res_in    (res),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res_out   (res_q)
  );

  assign m_tuser = res_q.data_write;
  assign m_tlast = res_q.frame_end;
  assign m_tdata = {6'd0, res_q.byte_count, res_q.quantity, res_q.reg_address,
                    res_q.func_code, res_q.frame_status, res_q.data_byte,
                    res_q.data_index};

endmodule

`default_nettype wire
